/* design/hpe_pkg.sv */
package hpe_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 32;
    localparam int IDX_W = 7;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_LSCAN,
        ST_RSCAN,
        ST_SWAP,
        ST_EMIT
    } hpe_state_t;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [KEY_W-1:0] key;
    } hpe_rec_t;

    function automatic logic key_is_nan(input logic [KEY_W-1:0] k);
        return (k[30:23] == 8'hFF) && (k[22:0] != 23'd0);
    endfunction

    function automatic logic [KEY_W-1:0] key_order(input logic [KEY_W-1:0] k);
        if (k[30:0] == 31'd0) begin
            return 32'h8000_0000;
        end else if (k[31]) begin
            return ~k;
        end else begin
            return k | 32'h8000_0000;
        end
    endfunction

    // IEEE less-than on raw bit patterns.
    function automatic logic key_less(input logic [KEY_W-1:0] a, input logic [KEY_W-1:0] b);
        if (key_is_nan(a) || key_is_nan(b)) begin
            return 1'b0;
        end else begin
            return key_order(a) < key_order(b);
        end
    endfunction

endpackage

/* design/hpe_store.sv */
module hpe_store
    import hpe_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  logic            aclk,
    input  logic            we_a,
    input  logic [AW-1:0]   addr_a,
    input  hpe_rec_t        wdata_a,
    input  logic            we_b,
    input  logic [AW-1:0]   addr_b,
    input  hpe_rec_t        wdata_b,
    input  logic [AW-1:0]   raddr,
    output hpe_rec_t        rdata
);

    hpe_rec_t mem [DEPTH];

    // Two write ports, port A taking priority, and one registered read port; a swap
    // writes its two entries one after the other, so only one write is ever active.
    always_ff @(posedge aclk) begin
        if (we_a) begin
            mem[addr_a] <= wdata_a;
        end else if (we_b) begin
            mem[addr_b] <= wdata_b;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/hoare_partition_engine_unit.sv */
// Channel | Direction | tdata fields (low bit up)          | tuser      | tlast
// s_axis  | input     | elem_tag[31:0], elem_key, pivot_key | -          | last_item
// m_axis  | output    | out_tag, out_key, split_index, pad  | -          | out_last
//
// Items are written to the store as they are accepted in the load state. After
// the last item, the partition pass runs: each scan phase issues its first read
// and then one read per pointer step, and each swap writes the right record into
// the left slot, then the saved left record into the right slot, then takes a
// turn-around step. Emission then shows the records in store order; the next
// store read is issued only when no read is pending and the output register is
// free or being taken; m_axis_tready low holds the item. The store needs no
// clearing after reset: only entries below the record count are ever used.
module hoare_partition_engine_unit
    import hpe_pkg::*;
#(
    parameter int MAX_RECORDS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // elem_tag [31:0], elem_key [63:32], pivot_key [95:64]
    input  logic [95:0]  s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_tag [31:0], out_key [63:32], split_index [70:64], zero [71]
    output logic [71:0]  m_axis_tdata,
    output logic         m_axis_tlast
);

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;

    hpe_state_t state_reg, state_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0] pivot_reg, pivot_next;
    // j is kept one above its true value to avoid going negative: jp = j+1.
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] jp_reg, jp_next;
    logic [IDX_W-1:0] split_reg, split_next;
    hpe_rec_t left_rec_reg, left_rec_next;
    logic             swap_ph_reg, swap_ph_next;
    logic             rd_pend_reg, rd_pend_next;
    // Emission: read address counter and output register.
    logic [IDX_W-1:0] eaddr_reg, eaddr_next;
    logic             ovalid_reg, ovalid_next;
    hpe_rec_t         orec_reg, orec_next;
    logic             olast_reg, olast_next;

    logic             we_a, we_b;
    logic [AW-1:0]    addr_a, addr_b, raddr;
    hpe_rec_t         wdata_a, wdata_b, rdata;
    logic             s_acc;
    logic             rscan_stop;

    hpe_store #(.DEPTH(MAX_RECORDS), .AW(AW)) u_store (
        .aclk    (aclk),
        .we_a    (we_a),
        .addr_a  (addr_a),
        .wdata_a (wdata_a),
        .we_b    (we_b),
        .addr_b  (addr_b),
        .wdata_b (wdata_b),
        .raddr   (raddr),
        .rdata   (rdata)
    );

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_LOAD);

    // Right scan stop: at index 0 (jp==1) or key not above pivot.
    assign rscan_stop = (jp_reg <= IDX_W'(1)) || !key_less(pivot_reg, rdata.key);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            pivot_reg   <= '0;
            i_reg       <= '0;
            jp_reg      <= '0;
            split_reg   <= '0;
            swap_ph_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
            eaddr_reg   <= '0;
            ovalid_reg  <= 1'b0;
            olast_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pivot_reg   <= pivot_next;
            i_reg       <= i_next;
            jp_reg      <= jp_next;
            split_reg   <= split_next;
            swap_ph_reg <= swap_ph_next;
            rd_pend_reg <= rd_pend_next;
            eaddr_reg   <= eaddr_next;
            ovalid_reg  <= ovalid_next;
            olast_reg   <= olast_next;
        end
        left_rec_reg <= left_rec_next;
        orec_reg     <= orec_next;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_acc && s_axis_tlast) begin
                    state_next = ST_LSCAN;
                end
            end
            ST_LSCAN: begin
                if (rd_pend_reg) begin
                    if (!(i_reg < count_reg) || !key_less(rdata.key, pivot_reg)) begin
                        state_next = ST_RSCAN;
                    end
                end else if (!(i_reg < count_reg)) begin
                    state_next = ST_RSCAN;
                end
            end
            ST_RSCAN: begin
                if (jp_reg == '0) begin
                    state_next = ST_EMIT;
                end else if (rd_pend_reg && rscan_stop) begin
                    if (i_reg < jp_reg - IDX_W'(1)) begin
                        state_next = ST_SWAP;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SWAP: begin
                if (swap_ph_reg) begin
                    state_next = ST_LSCAN;
                end
            end
            ST_EMIT: begin
                if (ovalid_reg && m_axis_tready && olast_reg) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        logic emit_adv;
        logic [IDX_W-1:0] jdec;
        count_next    = count_reg;
        pivot_next    = pivot_reg;
        i_next        = i_reg;
        jp_next       = jp_reg;
        split_next    = split_reg;
        left_rec_next = left_rec_reg;
        swap_ph_next  = 1'b0;
        rd_pend_next  = 1'b0;
        eaddr_next    = eaddr_reg;
        ovalid_next   = ovalid_reg;
        orec_next     = orec_reg;
        olast_next    = olast_reg;
        we_a          = 1'b0;
        we_b          = 1'b0;
        jdec          = jp_reg - IDX_W'(1);
        addr_a        = count_reg[AW-1:0];
        wdata_a       = {s_axis_tdata[31:0], s_axis_tdata[63:32]};
        addr_b        = jdec[AW-1:0];
        wdata_b       = left_rec_reg;
        raddr         = i_reg[AW-1:0];
        emit_adv      = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                if (s_acc) begin
                    if (count_reg < IDX_W'(MAX_RECORDS)) begin
                        we_a       = 1'b1;
                        count_next = count_reg + IDX_W'(1);
                    end
                    if (s_axis_tlast) begin
                        pivot_next = s_axis_tdata[95:64];
                        i_next     = '0;
                        // j starts at the record count, so jp starts one above it.
                        jp_next    = (count_reg < IDX_W'(MAX_RECORDS)) ?
                                     count_reg + IDX_W'(2) : count_reg + IDX_W'(1);
                    end
                end
            end
            ST_LSCAN: begin
                raddr = i_reg[AW-1:0];
                if (rd_pend_reg) begin
                    if (i_reg < count_reg && key_less(rdata.key, pivot_reg)) begin
                        i_next = i_reg + IDX_W'(1);
                        raddr  = i_next[AW-1:0];
                        rd_pend_next = 1'b1;
                    end else begin
                        left_rec_next = rdata;
                        jp_next = jdec;
                        raddr   = (jdec == '0) ? '0 : AW'(jdec - IDX_W'(1));
                        rd_pend_next = 1'b0;
                    end
                end else if (i_reg < count_reg) begin
                    rd_pend_next = 1'b1;
                end else begin
                    jp_next = jdec;
                end
            end
            ST_RSCAN: begin
                raddr = AW'(jdec);
                if (jp_reg == '0) begin
                    split_next = i_reg;
                end else if (!rd_pend_reg) begin
                    rd_pend_next = 1'b1;
                end else if (!rscan_stop) begin
                    jp_next = jdec;
                    raddr   = AW'(jdec - IDX_W'(1));
                    rd_pend_next = 1'b1;
                end else if (i_reg < jdec) begin
                    // Write the right record into the left slot first.
                    we_a    = 1'b1;
                    addr_a  = i_reg[AW-1:0];
                    wdata_a = rdata;
                end else begin
                    split_next = i_reg;
                end
            end
            ST_SWAP: begin
                // Second half of the swap: the saved left record goes right.
                we_b         = !swap_ph_reg;
                swap_ph_next = 1'b1;
                if (swap_ph_reg) begin
                    i_next = i_reg + IDX_W'(1);
                end
            end
            ST_EMIT: begin
                raddr = eaddr_reg[AW-1:0];
                if (ovalid_reg && m_axis_tready) begin
                    ovalid_next = 1'b0;
                    if (olast_reg) begin
                        count_next = '0;
                        eaddr_next = '0;
                    end
                end
                if (rd_pend_reg) begin
                    // Read data arrives for eaddr-1; load it into the output.
                    orec_next   = rdata;
                    ovalid_next = 1'b1;
                    olast_next  = (eaddr_reg == count_reg);
                end else if ((!ovalid_reg || m_axis_tready) && eaddr_reg < count_reg
                             && !(ovalid_reg && olast_reg)) begin
                    emit_adv = 1'b1;
                end
                if (emit_adv) begin
                    eaddr_next   = eaddr_reg + IDX_W'(1);
                    rd_pend_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = {1'b0, split_reg, orec_reg.key, orec_reg.tag};
    assign m_axis_tlast  = olast_reg;

endmodule

/* design/hpe_checker.sv */
module hpe_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [71:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // No input item is taken while results are being shown.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !(s_axis_tvalid && s_axis_tready))
        else $error("input accepted during emission");

    // Split index never exceeds 64, the default maximum block size.
    a_split_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata[70:64] <= 7'd64))
        else $error("split index out of range");

    // A stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Split index is constant within a block.
    a_split_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
        |-> m_axis_tdata[70:64] == $past(m_axis_tdata[70:64]))
        else $error("split index changed within block");

endmodule

bind hoare_partition_engine_unit hpe_checker u_hpe_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
